>>> rtl/eeprom_controller_registers_defines.svh
// Assertion macros for the EEPROM controller register block
`ifndef EEPROM_CONTROLLER_REGISTERS_DEFINES_SVH
`define EEPROM_CONTROLLER_REGISTERS_DEFINES_SVH

// same-cycle implication
`define EECR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eecr assertion failed");

// next-cycle implication
`define EECR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eecr assertion failed");

`endif

>>> rtl/eecr_pkg.sv
// Package: types, constants and helpers for the EEPROM controller register block
package eecr_pkg;

    localparam int DEPTH      = 512;
    localparam int ADDR_BITS  = 9;
    localparam int TIME_BITS  = 24;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CFG_TIME_W = 24;
    localparam bit SMALL_STORE = (DEPTH <= 256);

    localparam logic [TIME_BITS-1:0] TIME_ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};
    localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] SEL_ADDR_LO = 2'd0;
    localparam logic [1:0] SEL_ADDR_HI = 2'd1;
    localparam logic [1:0] SEL_DATA    = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    localparam int CTL_READ   = 0;
    localparam int CTL_WRITE  = 1;
    localparam int CTL_ENABLE = 2;
    localparam int CTL_IRQ    = 3;

    localparam logic [5:0] CTL_BASE_MASK = 6'h07;
    localparam logic [5:0] CTL_IRQ_MASK  = 6'h08;
    localparam logic [5:0] CTL_MODE_MASK = 6'h30;

    localparam logic [1:0] MODE_ERASE_WRITE = 2'd0;
    localparam logic [1:0] MODE_ERASE       = 2'd1;
    localparam logic [1:0] MODE_WRITE_ONLY  = 2'd2;

    localparam logic [2:0] ENABLE_WINDOW = 3'd4;
    localparam logic [2:0] HOLD_READ     = 3'd4;
    localparam logic [2:0] HOLD_WRITE    = 3'd2;

    localparam logic [7:0] ERASED = 8'hff;

    localparam logic [2:0] REG_ERASE_WRITE_TICKS = 3'd0;
    localparam logic [2:0] REG_ERASE_TICKS       = 3'd1;
    localparam logic [2:0] REG_WRITE_TICKS       = 3'd2;
    localparam logic [2:0] REG_MODE_BITS         = 3'd3;
    localparam logic [2:0] REG_IRQ_AVAILABLE     = 3'd4;

    typedef enum logic [1:0] {
        ST_READY,
        ST_ENABLED,
        ST_WRITE
    } op_state_t;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] erase_write_ticks;
        logic [CFG_TIME_W-1:0] erase_ticks;
        logic [CFG_TIME_W-1:0] write_ticks;
        logic                  mode_bits_enabled;
        logic                  irq_available;
    } cfg_t;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        logic [7:0]          wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       cpu_hold;
        logic       irq_request;
        logic       bad_high_address;
    } result_t;

    // saturate a configured duration to the timer width
    function automatic logic [TIME_BITS-1:0] clip_time(input logic [CFG_TIME_W-1:0] t);
        logic [31:0] t32;
        t32 = 32'(t);
        if (t32 > TIME_MAX32)
        begin
            t32 = TIME_MAX32;
        end
        return TIME_BITS'(t32);
    endfunction

endpackage

>>> rtl/eecr_cfg.sv
// Configuration register file behind the APB-style port
module eecr_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output eecr_pkg::cfg_t     cfg
);
    import eecr_pkg::*;

    logic [CFG_TIME_W-1:0] erase_write_ticks_reg;
    logic [CFG_TIME_W-1:0] erase_ticks_reg;
    logic [CFG_TIME_W-1:0] write_ticks_reg;
    logic                  mode_bits_reg;
    logic                  irq_available_reg;
    logic [2:0]            index;
    logic                  wr;

    assign index  = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_write_ticks_reg <= CFG_TIME_W'(68000);
            erase_ticks_reg       <= CFG_TIME_W'(14400);
            write_ticks_reg       <= CFG_TIME_W'(14400);
            mode_bits_reg         <= 1'b0;
            irq_available_reg     <= 1'b1;
        end
        else if (wr)
        begin
            case (index)
                REG_ERASE_WRITE_TICKS: erase_write_ticks_reg <= pwdata[CFG_TIME_W-1:0];
                REG_ERASE_TICKS:       erase_ticks_reg       <= pwdata[CFG_TIME_W-1:0];
                REG_WRITE_TICKS:       write_ticks_reg       <= pwdata[CFG_TIME_W-1:0];
                REG_MODE_BITS:         mode_bits_reg         <= pwdata[0];
                REG_IRQ_AVAILABLE:     irq_available_reg     <= pwdata[0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_ERASE_WRITE_TICKS: prdata = 32'(erase_write_ticks_reg);
            REG_ERASE_TICKS:       prdata = 32'(erase_ticks_reg);
            REG_WRITE_TICKS:       prdata = 32'(write_ticks_reg);
            REG_MODE_BITS:         prdata = 32'(mode_bits_reg);
            REG_IRQ_AVAILABLE:     prdata = 32'(irq_available_reg);
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.erase_write_ticks = erase_write_ticks_reg;
    assign cfg.erase_ticks       = erase_ticks_reg;
    assign cfg.write_ticks       = write_ticks_reg;
    assign cfg.mode_bits_enabled = mode_bits_reg;
    assign cfg.irq_available     = irq_available_reg;

endmodule

>>> rtl/eecr_cell_ram.sv
// Cell store: single-port-write, registered-read RAM with clearing sweep after reset
module eecr_cell_ram (
    input  logic               clk,
    input  logic               rst_n,
    input  eecr_pkg::mem_req_t req,
    output logic [7:0]         rdata,
    output logic               clearing
);
    import eecr_pkg::*;

    logic [7:0]          cells [DEPTH];
    logic                clear_busy_reg;
    logic [IDX_BITS-1:0] clear_addr_reg;
    logic                we;
    logic [IDX_BITS-1:0] wa;
    logic [7:0]          wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == IDX_BITS'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    assign clearing = clear_busy_reg;
    assign we = clear_busy_reg | req.wr_en;
    assign wa = clear_busy_reg ? clear_addr_reg : req.wr_addr;
    assign wd = clear_busy_reg ? ERASED : req.wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells[wa] <= wd;
        end
        if (req.rd_en)
        begin
            rdata <= cells[req.rd_addr];
        end
    end

endmodule

>>> rtl/eecr_core.sv
// Register file, operation sequencer and cell read-modify-write control
module eecr_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [1:0]                  command,
    input  logic [1:0]                  reg_select,
    input  logic [7:0]                  write_data,
    input  eecr_pkg::cfg_t              cfg,
    input  logic [7:0]                  mem_rdata,
    output eecr_pkg::mem_req_t          mem_req,
    output eecr_pkg::result_t           res
);
    import eecr_pkg::*;

    op_state_t              state_reg, state_next;
    logic [ADDR_BITS-1:0]   address_reg, address_next;
    logic [7:0]             data_reg, data_next;
    logic [5:0]             control_reg, control_next;
    logic [2:0]             enable_cnt_reg, enable_cnt_next;
    logic [2:0]             hold_cnt_reg, hold_cnt_next;
    logic [1:0]             op_mode_reg, op_mode_next;
    logic [ADDR_BITS-1:0]   op_addr_reg, op_addr_next;
    logic [TIME_BITS-1:0]   busy_reg, busy_next;

    // second stage: cell data back from the RAM
    logic                   s2_load_reg, s2_load_next;
    logic                   s2_done_reg, s2_done_next;
    logic [1:0]             s2_mode_reg, s2_mode_next;
    logic [IDX_BITS-1:0]    s2_addr_reg, s2_addr_next;
    logic [7:0]             s2_data_reg, s2_data_next;
    logic                   s2_fwd_reg, s2_fwd_next;
    logic [7:0]             s2_fwd_data_reg, s2_fwd_data_next;

    logic [7:0]             rd_val;
    logic [7:0]             data_eff;
    logic [7:0]             wb_data;
    logic                   load_start;
    logic                   done_start;
    logic [IDX_BITS-1:0]    rd_addr;
    logic [5:0]             ctl_mask;
    logic [5:0]             ctl_w;
    logic [15:0]            addr16;
    logic [CFG_TIME_W-1:0]  dur;

    assign rd_val   = s2_fwd_reg ? s2_fwd_data_reg : mem_rdata;
    assign data_eff = s2_load_reg ? rd_val : data_reg;
    assign addr16   = 16'(address_reg);

    always_comb
    begin
        case (s2_mode_reg)
            MODE_ERASE:      wb_data = ERASED;
            MODE_WRITE_ONLY: wb_data = s2_data_reg & rd_val;
            default:         wb_data = s2_data_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        address_next    = address_reg;
        data_next       = data_eff;
        control_next    = control_reg;
        enable_cnt_next = enable_cnt_reg;
        hold_cnt_next   = hold_cnt_reg;
        op_mode_next    = op_mode_reg;
        op_addr_next    = op_addr_reg;
        busy_next       = busy_reg;
        load_start      = 1'b0;
        done_start      = 1'b0;
        res             = '0;
        ctl_mask        = CTL_BASE_MASK
                        | (cfg.irq_available ? CTL_IRQ_MASK : 6'h00)
                        | (cfg.mode_bits_enabled ? CTL_MODE_MASK : 6'h00);
        ctl_w           = write_data[5:0] & ctl_mask;
        case (ctl_w[5:4])
            MODE_ERASE:      dur = cfg.erase_ticks;
            MODE_WRITE_ONLY: dur = cfg.write_ticks;
            default:         dur = cfg.erase_write_ticks;
        endcase

        if (take)
        begin
            case (command)
                CMD_TICK:
                begin
                    if (enable_cnt_reg != 3'd0)
                    begin
                        enable_cnt_next = enable_cnt_reg - 3'd1;
                        if (enable_cnt_reg == 3'd1)
                        begin
                            control_next[CTL_ENABLE] = 1'b0;
                            if (state_reg == ST_ENABLED)
                            begin
                                state_next = ST_READY;
                            end
                        end
                    end
                    if (state_reg == ST_WRITE)
                    begin
                        if (busy_reg != '0)
                        begin
                            busy_next = busy_reg - TIME_ONE;
                        end
                        if (busy_reg == '0 || busy_reg == TIME_ONE)
                        begin
                            state_next              = ST_READY;
                            control_next[CTL_WRITE] = 1'b0;
                            done_start              = 1'b1;
                            res.irq_request = cfg.irq_available & control_reg[CTL_IRQ];
                        end
                    end
                    if (hold_cnt_reg != 3'd0)
                    begin
                        hold_cnt_next = hold_cnt_reg - 3'd1;
                        res.cpu_hold  = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    case (reg_select)
                        SEL_ADDR_LO: address_next = ADDR_BITS'({addr16[15:8], write_data});
                        SEL_ADDR_HI:
                        begin
                            address_next = ADDR_BITS'({write_data, addr16[7:0]});
                            res.bad_high_address = SMALL_STORE && (write_data != 8'd0);
                        end
                        SEL_DATA: data_next = write_data;
                        default:
                        begin
                            case (state_reg)
                                ST_ENABLED:
                                begin
                                    ctl_w[CTL_ENABLE] = 1'b1;
                                    if (ctl_w[CTL_READ])
                                    begin
                                        hold_cnt_next   = HOLD_READ;
                                        load_start      = 1'b1;
                                        ctl_w[CTL_READ] = 1'b0;
                                    end
                                    else if (ctl_w[CTL_WRITE])
                                    begin
                                        hold_cnt_next     = HOLD_WRITE;
                                        op_mode_next      = ctl_w[5:4];
                                        op_addr_next      = address_reg;
                                        state_next        = ST_WRITE;
                                        enable_cnt_next   = 3'd0;
                                        ctl_w[CTL_ENABLE] = 1'b0;
                                        busy_next         = clip_time(dur);
                                    end
                                end
                                ST_WRITE:
                                begin
                                    if (ctl_w[CTL_ENABLE])
                                    begin
                                        enable_cnt_next = ENABLE_WINDOW;
                                    end
                                    ctl_w[CTL_READ]  = 1'b0;
                                    ctl_w[CTL_WRITE] = 1'b1;
                                end
                                default:
                                begin
                                    state_next = ST_READY;
                                    if (ctl_w[CTL_ENABLE])
                                    begin
                                        state_next      = ST_ENABLED;
                                        enable_cnt_next = ENABLE_WINDOW;
                                    end
                                    if (ctl_w[CTL_READ])
                                    begin
                                        hold_cnt_next   = HOLD_READ;
                                        load_start      = 1'b1;
                                        ctl_w[CTL_READ] = 1'b0;
                                    end
                                    ctl_w[CTL_WRITE] = 1'b0;
                                end
                            endcase
                            control_next = ctl_w;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    case (reg_select)
                        SEL_ADDR_LO: res.read_data = addr16[7:0];
                        SEL_ADDR_HI: res.read_data = addr16[15:8];
                        SEL_DATA:    res.read_data = data_eff;
                        default:     res.read_data = 8'(control_reg);
                    endcase
                end
                default: ;
            endcase
        end

        rd_addr          = load_start ? address_reg[IDX_BITS-1:0] : op_addr_reg[IDX_BITS-1:0];
        s2_load_next     = load_start;
        s2_done_next     = done_start;
        s2_mode_next     = op_mode_reg;
        s2_addr_next     = op_addr_reg[IDX_BITS-1:0];
        s2_data_next     = data_eff;
        // write-back lands at the same edge as this read: bypass
        s2_fwd_next      = s2_done_reg && (load_start || done_start) && (s2_addr_reg == rd_addr);
        s2_fwd_data_next = wb_data;

        mem_req.rd_en   = load_start | done_start;
        mem_req.rd_addr = rd_addr;
        mem_req.wr_en   = s2_done_reg;
        mem_req.wr_addr = s2_addr_reg;
        mem_req.wr_data = wb_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_READY;
            address_reg    <= '0;
            data_reg       <= '0;
            control_reg    <= '0;
            enable_cnt_reg <= '0;
            hold_cnt_reg   <= '0;
            op_mode_reg    <= MODE_ERASE_WRITE;
            op_addr_reg    <= '0;
            busy_reg       <= '0;
            s2_load_reg    <= 1'b0;
            s2_done_reg    <= 1'b0;
            s2_fwd_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            address_reg    <= address_next;
            data_reg       <= data_next;
            control_reg    <= control_next;
            enable_cnt_reg <= enable_cnt_next;
            hold_cnt_reg   <= hold_cnt_next;
            op_mode_reg    <= op_mode_next;
            op_addr_reg    <= op_addr_next;
            busy_reg       <= busy_next;
            s2_load_reg    <= s2_load_next;
            s2_done_reg    <= s2_done_next;
            s2_fwd_reg     <= s2_fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg     <= s2_mode_next;
        s2_addr_reg     <= s2_addr_next;
        s2_data_reg     <= s2_data_next;
        s2_fwd_data_reg <= s2_fwd_data_next;
    end

endmodule

>>> rtl/eeprom_controller_registers.sv
// Top level: EEPROM controller register block with command and response channels
// One command transfer per clock while cmd_stall is low; its response is registered in
// the output register, and the next command is taken in the cycle that this response
// leaves, so cmd_stall follows rsp_stall while a response waits. The 512-byte cell store
// is one RAM (one write, one registered read per cycle). A data load passes through the
// RAM read register into the data register. Each completion reads its cell and writes it
// back the following cycle, with a bypass when the next access hits the same cell. After
// reset the RAM is swept to 0xff, with cmd_stall high during the sweep; configuration
// writes are taken throughout.
`include "eeprom_controller_registers_defines.svh"

module eeprom_controller_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  reg_select,
    input  logic [7:0]  write_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  read_data,
    output logic        cpu_hold,
    output logic        irq_request,
    output logic        bad_high_address
);
    import eecr_pkg::*;

    cfg_t       cfg;
    mem_req_t   mem_req;
    result_t    res;
    logic [7:0] mem_rdata;
    logic       clearing;
    logic       take;
    logic       rsp_valid_reg, rsp_valid_next;
    result_t    rsp_reg;

    assign cmd_stall = clearing | (rsp_valid_reg & rsp_stall);
    assign take      = cmd_valid & ~cmd_stall;

    eecr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eecr_cell_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    eecr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .command    (command),
        .reg_select (reg_select),
        .write_data (write_data),
        .cfg        (cfg),
        .mem_rdata  (mem_rdata),
        .mem_req    (mem_req),
        .res        (res)
    );

    assign rsp_valid_next = take | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign read_data        = rsp_reg.read_data;
    assign cpu_hold         = rsp_reg.cpu_hold;
    assign irq_request      = rsp_reg.irq_request;
    assign bad_high_address = rsp_reg.bad_high_address;

    `EECR_ASSERT_NOW(a_no_take_while_clearing, clk, rst_n, clearing, !take)
    `EECR_ASSERT_NOW(a_no_core_write_while_clearing, clk, rst_n, clearing, !mem_req.wr_en)
    `EECR_ASSERT_NEXT(a_irq_then_writeback, clk, rst_n, take && res.irq_request, mem_req.wr_en)

endmodule

>>> bench/eecr_response_checker.sv
// Response checker for the EEPROM controller register block: predicts and compares every transfer
module eecr_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [7:0]  read_data,
    input  logic        cpu_hold,
    input  logic        irq_request,
    input  logic        bad_high_address,
    output int          failures,
    output int          outstanding
);
    import eecr_pkg::*;

    logic [7:0]           cells [DEPTH];
    logic [ADDR_BITS-1:0] addr_q;
    logic [7:0]           data_q;
    logic [5:0]           ctl_q;
    op_state_t            state_q;
    logic [2:0]           window_cnt;
    logic [2:0]           hold_cnt;
    logic [1:0]           mode_q;
    logic [ADDR_BITS-1:0] target_q;
    logic [TIME_BITS-1:0] busy_cnt;
    cfg_t                 cfg;
    result_t              responses_due [$];

    task automatic predict_response(input logic [1:0] cmd, input logic [1:0] sel,
                                    input logic [7:0] v, output result_t r);
        logic [5:0]  mask;
        logic [31:0] wide;
        logic [31:0] span;
        int          idx;
        r = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (window_cnt != 0)
                begin
                    window_cnt = window_cnt - 3'd1;
                    if (window_cnt == 0)
                    begin
                        ctl_q[CTL_ENABLE] = 1'b0;
                        if (state_q == ST_ENABLED)
                        begin
                            state_q = ST_READY;
                        end
                    end
                end
                if (state_q == ST_WRITE)
                begin
                    if (busy_cnt != 0)
                    begin
                        busy_cnt = busy_cnt - 1'b1;
                    end
                    if (busy_cnt == 0)
                    begin
                        idx = int'(target_q) % DEPTH;
                        state_q = ST_READY;
                        ctl_q[CTL_WRITE] = 1'b0;
                        case (mode_q)
                            MODE_ERASE:      cells[idx] = ERASED;
                            MODE_WRITE_ONLY: cells[idx] = cells[idx] & data_q;
                            default:         cells[idx] = data_q;
                        endcase
                        r.irq_request = cfg.irq_available && ctl_q[CTL_IRQ];
                    end
                end
                if (hold_cnt != 0)
                begin
                    hold_cnt = hold_cnt - 3'd1;
                    r.cpu_hold = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                case (sel)
                    SEL_ADDR_LO:
                    begin
                        wide = (32'(addr_q) & 32'hff00) + 32'(v);
                        addr_q = ADDR_BITS'(wide);
                    end
                    SEL_ADDR_HI:
                    begin
                        r.bad_high_address = SMALL_STORE && (v != 8'h00);
                        wide = (32'(addr_q) & 32'h00ff) + (32'(v) << 8);
                        addr_q = ADDR_BITS'(wide);
                    end
                    SEL_DATA:
                    begin
                        data_q = v;
                    end
                    default:
                    begin
                        mask = CTL_BASE_MASK;
                        if (cfg.irq_available)
                        begin
                            mask = mask | CTL_IRQ_MASK;
                        end
                        if (cfg.mode_bits_enabled)
                        begin
                            mask = mask | CTL_MODE_MASK;
                        end
                        ctl_q = v[5:0] & mask;
                        if (state_q == ST_ENABLED)
                        begin
                            ctl_q[CTL_ENABLE] = 1'b1;
                            if (ctl_q[CTL_READ])
                            begin
                                hold_cnt = HOLD_READ;
                                data_q = cells[int'(addr_q) % DEPTH];
                                ctl_q[CTL_READ] = 1'b0;
                            end
                            else if (ctl_q[CTL_WRITE])
                            begin
                                hold_cnt = HOLD_WRITE;
                                mode_q = ctl_q[5:4];
                                target_q = addr_q;
                                state_q = ST_WRITE;
                                window_cnt = '0;
                                ctl_q[CTL_ENABLE] = 1'b0;
                                case (mode_q)
                                    MODE_ERASE:      span = 32'(cfg.erase_ticks);
                                    MODE_WRITE_ONLY: span = 32'(cfg.write_ticks);
                                    default:         span = 32'(cfg.erase_write_ticks);
                                endcase
                                busy_cnt = (span > TIME_MAX32) ? TIME_BITS'(TIME_MAX32)
                                                               : TIME_BITS'(span);
                            end
                        end
                        else if (state_q == ST_WRITE)
                        begin
                            if (ctl_q[CTL_ENABLE])
                            begin
                                window_cnt = ENABLE_WINDOW;
                            end
                            ctl_q[CTL_READ] = 1'b0;
                            ctl_q[CTL_WRITE] = 1'b1;
                        end
                        else
                        begin
                            state_q = ST_READY;
                            if (ctl_q[CTL_ENABLE])
                            begin
                                state_q = ST_ENABLED;
                                window_cnt = ENABLE_WINDOW;
                            end
                            if (ctl_q[CTL_READ])
                            begin
                                hold_cnt = HOLD_READ;
                                data_q = cells[int'(addr_q) % DEPTH];
                                ctl_q[CTL_READ] = 1'b0;
                            end
                            ctl_q[CTL_WRITE] = 1'b0;
                        end
                    end
                endcase
            end
            CMD_READ:
            begin
                case (sel)
                    SEL_ADDR_LO: r.read_data = 8'(32'(addr_q) & 32'h00ff);
                    SEL_ADDR_HI: r.read_data = 8'(32'(addr_q) >> 8);
                    SEL_DATA:    r.read_data = data_q;
                    default:     r.read_data = 8'(ctl_q);
                endcase
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, label, want, got);
            failures = failures + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cells[i] = ERASED;
            end
            addr_q = '0;
            data_q = '0;
            ctl_q = '0;
            state_q = ST_READY;
            window_cnt = '0;
            hold_cnt = '0;
            mode_q = MODE_ERASE_WRITE;
            target_q = '0;
            busy_cnt = '0;
            cfg.erase_write_ticks = 24'd68000;
            cfg.erase_ticks = 24'd14400;
            cfg.write_ticks = 24'd14400;
            cfg.mode_bits_enabled = 1'b0;
            cfg.irq_available = 1'b1;
            responses_due.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_ERASE_WRITE_TICKS: cfg.erase_write_ticks = pwdata[CFG_TIME_W-1:0];
                    REG_ERASE_TICKS:       cfg.erase_ticks = pwdata[CFG_TIME_W-1:0];
                    REG_WRITE_TICKS:       cfg.write_ticks = pwdata[CFG_TIME_W-1:0];
                    REG_MODE_BITS:         cfg.mode_bits_enabled = pwdata[0];
                    REG_IRQ_AVAILABLE:     cfg.irq_available = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd_valid && !cmd_stall)
            begin
                predict_response(command, reg_select, write_data, r);
                responses_due.push_back(r);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (responses_due.size() == 0)
                begin
                    $display("%0t: response transfer with nothing outstanding", $time);
                    failures = failures + 1;
                end
                else
                begin
                    r = responses_due.pop_front();
                    check_field("read_data", r.read_data, read_data);
                    check_field("cpu_hold", 8'(r.cpu_hold), 8'(cpu_hold));
                    check_field("irq_request", 8'(r.irq_request), 8'(irq_request));
                    check_field("bad_high_address", 8'(r.bad_high_address),
                                8'(bad_high_address));
                end
            end
            outstanding <= responses_due.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Testbench top for the EEPROM controller register block: clock, reset, stimulus and verdict
module tb_top;
    import eecr_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] CB_READ     = 8'(1 << CTL_READ);
    localparam logic [7:0] CB_WRITE    = 8'(1 << CTL_WRITE);
    localparam logic [7:0] CB_ENABLE   = 8'(1 << CTL_ENABLE);
    localparam logic [7:0] CB_IRQ      = 8'(1 << CTL_IRQ);
    localparam logic [7:0] CB_ERASE    = 8'({MODE_ERASE, 4'h0});
    localparam logic [7:0] CB_WONLY    = 8'({MODE_WRITE_ONLY, 4'h0});
    localparam logic [7:0] CB_MODE_ALL = 8'(CTL_MODE_MASK);
    localparam int         TICKS_MAX   = 24'hffffff;
    localparam int         CYCLE_LIMIT = 300000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [1:0]  reg_select;
    logic [7:0]  write_data;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [7:0]  read_data;
    logic        cpu_hold;
    logic        irq_request;
    logic        bad_high_address;
    int          failures;
    int          outstanding;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    int          tick_budget;

    eeprom_controller_registers dut (.*);
    eecr_response_checker checker_i (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] sel, input logic [7:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        command    <= cmd;
        reg_select <= sel;
        write_data <= v;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    task automatic configure(input int ew, input int er, input int wo, input bit modes,
                             input bit irq);
        int longest;
        settle();
        apb_write(REG_ERASE_WRITE_TICKS, 32'(ew));
        apb_write(REG_ERASE_TICKS, 32'(er));
        apb_write(REG_WRITE_TICKS, 32'(wo));
        apb_write(REG_MODE_BITS, 32'(modes));
        apb_write(REG_IRQ_AVAILABLE, 32'(irq));
        longest = (ew > er) ? ew : er;
        longest = (wo > longest) ? wo : longest;
        tick_budget = ((longest > 24) ? 24 : longest) + 3;
    endtask

    task automatic random_item();
        send_cmd(2'($urandom), 2'($urandom), 8'($urandom));
    endtask

    // well-formed program cycle: address, data, enable, strobe, wait, read back
    task automatic program_cell();
        logic [7:0] modes;
        logic [7:0] extra;
        modes = 8'({2'($urandom_range(3)), 4'h0});
        extra = $urandom_range(1) ? CB_IRQ : 8'h00;
        if ($urandom_range(1))
        begin
            send_cmd(CMD_WRITE, SEL_ADDR_LO,
                     $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(3)));
        end
        if ($urandom_range(3) == 0)
        begin
            send_cmd(CMD_WRITE, SEL_ADDR_HI, 8'($urandom));
        end
        send_cmd(CMD_WRITE, SEL_DATA, 8'($urandom));
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_ENABLE | extra | modes);
        repeat (($urandom_range(9) == 0) ? 4 : $urandom_range(3))
        begin
            send_cmd(CMD_TICK, 2'($urandom), 8'($urandom));
        end
        send_cmd(CMD_WRITE, SEL_CONTROL,
                 CB_WRITE | extra | modes | (($urandom_range(6) == 0) ? CB_READ : 8'h00));
        repeat (($urandom_range(4) == 0) ? $urandom_range(tick_budget) : tick_budget)
        begin
            if ($urandom_range(5) == 0)
            begin
                random_item();
            end
            else
            begin
                send_cmd(CMD_TICK, 2'($urandom), 8'($urandom));
            end
        end
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_READ | extra);
        send_cmd(CMD_READ, SEL_DATA, 8'($urandom));
        if ($urandom_range(1))
        begin
            send_cmd(CMD_READ, SEL_CONTROL, 8'($urandom));
        end
    endtask

    task automatic random_run(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                program_cell();
            end
            else
            begin
                random_item();
            end
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        cmd_valid  <= 1'b0;
        command    <= CMD_TICK;
        reg_select <= SEL_ADDR_LO;
        write_data <= '0;
        rsp_stall  <= 1'b0;
        recv_idle_pct <= 75;
        send_idle_pct = 16;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        configure(3, 0, 1, 1'b1, 1'b1);
        send_cmd(CMD_UNUSED, SEL_CONTROL, 8'hff);
        send_cmd(CMD_WRITE, SEL_ADDR_LO, 8'hff);
        send_cmd(CMD_WRITE, SEL_ADDR_HI, 8'hff);
        send_cmd(CMD_READ, SEL_ADDR_HI, 8'h00);
        send_cmd(CMD_READ, SEL_ADDR_LO, 8'h00);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_ENABLE | CB_IRQ);
        // read and write strobes together while enabled
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_READ | CB_WRITE | CB_IRQ);
        send_cmd(CMD_READ, SEL_CONTROL, 8'h00);
        send_cmd(CMD_WRITE, SEL_DATA, 8'h00);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_WRITE | CB_IRQ);
        // control write while busy, restarting the enable window
        send_cmd(CMD_WRITE, SEL_CONTROL, 8'hff);
        send_cmd(CMD_READ, SEL_CONTROL, 8'h00);
        repeat (4) send_cmd(CMD_TICK, SEL_ADDR_LO, 8'h00);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_READ);
        send_cmd(CMD_READ, SEL_DATA, 8'h00);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_ENABLE | CB_ERASE);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_WRITE | CB_ERASE);
        send_cmd(CMD_TICK, SEL_DATA, 8'hff);
        send_cmd(CMD_WRITE, SEL_ADDR_LO, 8'h00);
        send_cmd(CMD_WRITE, SEL_DATA, 8'h5a);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_ENABLE | CB_WONLY | CB_IRQ);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_WRITE | CB_WONLY | CB_IRQ);
        send_cmd(CMD_TICK, SEL_CONTROL, 8'h00);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_ENABLE | CB_MODE_ALL);
        send_cmd(CMD_WRITE, SEL_CONTROL, CB_WRITE | CB_MODE_ALL);
        repeat (4) send_cmd(CMD_TICK, SEL_ADDR_HI, 8'h00);

        configure($urandom_range(12), $urandom_range(12), $urandom_range(12), 1'b1, 1'b1);
        random_run(330);

        send_idle_pct = 75;
        recv_idle_pct <= 16;
        configure($urandom_range(20), $urandom_range(20), $urandom_range(20), 1'b0, 1'b0);
        random_run(330);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        configure($urandom_range(6), 0, $urandom_range(6), 1'b1, 1'b1);
        random_run(340);

        // longest durations last: an operation started here never completes
        configure(TICKS_MAX, TICKS_MAX, TICKS_MAX, 1'b1, 1'b1);
        random_run(40);

        settle();
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
